// ===== rtl/fbpe_pkg.sv =====
// ----------------------------------------------------------------------------
// fbpe_pkg
// Shared types, constants and functions of the filename byte percent escaper.
// ----------------------------------------------------------------------------
`default_nettype none

package fbpe_pkg;

	localparam int CntW = 11;
	localparam int DefaultMaxLen = 1024;
	localparam int ResetCapacity = 1024;

	localparam logic [7:0] PercentChar = 8'h25;
	localparam logic [7:0] NulChar = 8'h00;
	localparam logic [3:0] NibbleMask = 4'hf;

	// Number of result beats for one item
	localparam logic [1:0] CountNone = 2'd0;
	localparam logic [1:0] CountOne = 2'd1;
	localparam logic [1:0] CountThree = 2'd3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       first_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic [1:0]          count;
		logic [2:0][7:0]     bytes;
		logic [CntW-1:0]     cnt_base;
		logic                failed;
		logic                finished;
	} bundle_t;

	function automatic logic needs_escape(input logic [7:0] c);
		logic res;
		res = 1'b0;
		if (c < 8'h20) begin
			res = 1'b1;
		end else begin
			case (c)
				8'h22, 8'h2a, 8'h3a, 8'h3c, 8'h3e, 8'h3f, 8'h7c, 8'h7f,
				8'h80, 8'h81, 8'h8d, 8'h8e, 8'h8f, 8'h90, 8'h9d, 8'h9e: res = 1'b1;
				default: res = 1'b0;
			endcase
		end
		return res;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		logic [7:0] res;
		if (v < 4'd10) begin
			res = 8'h30 + {4'd0, v};
		end else begin
			res = 8'h57 + {4'd0, v};
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/fbpe_step.sv =====
// ----------------------------------------------------------------------------
// fbpe_step
// String state, capacity register and the per-byte escape decision.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpe_step #(
	parameter int MAX_LEN = fbpe_pkg::DefaultMaxLen
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_valid,
	input  wire  [fbpe_pkg::CntW-1:0]    cfg_data,
	input  wire  fbpe_pkg::item_t        item,
	input  wire                          advance,
	output fbpe_pkg::bundle_t            bundle
);
	import fbpe_pkg::*;

	localparam int LimitI = (MAX_LEN > 2047) ? 2047 : MAX_LEN;
	localparam logic [CntW-1:0] LimitC = CntW'(LimitI);
	localparam logic [CntW-1:0] ResetSpaceC =
		(ResetCapacity > LimitI) ? CntW'(LimitI) : CntW'(ResetCapacity);

	logic [CntW-1:0] capacity_q;
	logic [CntW-1:0] space_left_q;
	logic [CntW-1:0] bytes_written_q;
	logic            done_q;

	logic [CntW-1:0] cap_sat;
	logic [CntW-1:0] sl;
	logic [CntW-1:0] bw;
	logic            done;
	logic [CntW-1:0] sl_next;
	logic [CntW-1:0] bw_next;
	logic            done_next;
	logic            ends;

	assign cap_sat = (capacity_q > LimitC) ? LimitC : capacity_q;

	always_comb begin
		sl = item.first_byte ? cap_sat : space_left_q;
		bw = item.first_byte ? '0 : bytes_written_q;
		done = item.first_byte ? 1'b0 : done_q;
		sl_next = sl;
		bw_next = bw;
		done_next = done;
		ends = 1'b0;
		bundle.count = CountNone;
		bundle.bytes = '0;
		bundle.cnt_base = bw + CntW'(1);
		bundle.failed = 1'b0;
		bundle.finished = 1'b0;
		if (done) begin
			bundle.count = CountNone;
		end else if (sl == '0) begin
			done_next = 1'b1;
		end else if (item.in_byte == NulChar) begin
			bundle.count = CountOne;
			bundle.bytes[0] = NulChar;
			sl_next = sl - CntW'(1);
			bw_next = bw + CntW'(1);
			ends = 1'b1;
		end else if (needs_escape(item.in_byte)) begin
			if (sl < CntW'(3)) begin
				// Escape without room: a lone NUL that reports failure
				bundle.count = CountOne;
				bundle.bytes[0] = NulChar;
				bundle.cnt_base = '0;
				bundle.failed = 1'b1;
				ends = 1'b1;
			end else begin
				bundle.count = CountThree;
				bundle.bytes[0] = PercentChar;
				bundle.bytes[1] = hex_digit(item.in_byte[7:4]);
				bundle.bytes[2] = hex_digit(item.in_byte[3:0] & NibbleMask);
				sl_next = sl - CntW'(3);
				bw_next = bw + CntW'(3);
			end
		end else begin
			bundle.count = CountOne;
			bundle.bytes[0] = item.in_byte;
			sl_next = sl - CntW'(1);
			bw_next = bw + CntW'(1);
		end
		if (bundle.count != CountNone) begin
			if (item.last_byte || sl_next == '0) begin
				ends = 1'b1;
			end
			if (ends) begin
				done_next = 1'b1;
			end
			bundle.finished = ends;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CntW'(ResetCapacity);
		end else if (cfg_valid) begin
			capacity_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			space_left_q <= ResetSpaceC;
			bytes_written_q <= '0;
			done_q <= 1'b0;
		end else if (advance) begin
			space_left_q <= sl_next;
			bytes_written_q <= bw_next;
			done_q <= done_next;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/fbpe_serial.sv =====
// ----------------------------------------------------------------------------
// fbpe_serial
// Result register that hands out the beats of one item, one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpe_serial (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          load,
	input  wire  fbpe_pkg::bundle_t      bundle_in,
	output logic                         free,
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [23:0]                  m_tdata,   // out_byte[7:0], written_count[18:8]
	output logic                         m_tlast,   // run_last
	output logic [1:0]                   m_tuser    // finished[0], failed[1]
);
	import fbpe_pkg::*;

	bundle_t         bnd_q;
	logic            bvalid_q;
	logic [1:0]      idx_q;
	logic            last_beat;
	logic [CntW-1:0] cnt;

	assign last_beat = (idx_q == bnd_q.count - 2'd1);
	assign free = !bvalid_q || (m_tready && last_beat);

	assign cnt = bnd_q.failed ? '0 : bnd_q.cnt_base + {{(CntW-2){1'b0}}, idx_q};
	assign m_tvalid = bvalid_q;
	assign m_tdata = {5'd0, cnt, bnd_q.bytes[idx_q]};
	assign m_tlast = last_beat;
	assign m_tuser = {bnd_q.failed, bnd_q.finished && last_beat};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bvalid_q <= 1'b0;
			idx_q <= 2'd0;
		end else if (load) begin
			bvalid_q <= 1'b1;
			idx_q <= 2'd0;
		end else if (bvalid_q && m_tready) begin
			if (last_beat) begin
				bvalid_q <= 1'b0;
			end
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bnd_q <= bundle_in;
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		bvalid_q |-> (idx_q < bnd_q.count)) else $error("beat index past count");
	a_fail_single: assert property (@(posedge clk) disable iff (!arst_n)
		(bvalid_q && bnd_q.failed) |-> (bnd_q.count == CountOne && bnd_q.finished))
		else $error("failed result is not a single finishing beat");
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (free && bundle_in.count != CountNone))
		else $error("result register loaded while busy or with no beats");

endmodule

`default_nettype wire

// ===== rtl/filename_byte_percent_escaper.sv =====
// An accepted byte is registered in the input stage, its escape decision is then
// loaded into the result register, and that register offers its first result on the result port.
// Copied and zero bytes flow at one byte per cycle while m_tready is high; an escaped byte
// occupies the result register for three transfers, one per hex-escape byte,
// so the input stalls behind it until the last of them transfers.
// Reset (arst_n low) empties both registers, clears the byte count and done flag, sets the
// space left to the lower of 1024 and MAX_LEN, and sets the output capacity to 1024.
// ----------------------------------------------------------------------------
// filename_byte_percent_escaper
// Streams a byte string and percent-escapes bytes not allowed in file names.
// ----------------------------------------------------------------------------
`default_nettype none

module filename_byte_percent_escaper #(
	parameter int MAX_LEN = fbpe_pkg::DefaultMaxLen
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [fbpe_pkg::CntW-1:0]    cfg_data,   // output_capacity
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire  [7:0]                   s_tdata,    // in_byte[7:0]
	input  wire                          s_tlast,    // last_byte
	input  wire  [0:0]                   s_tuser,    // first_byte[0]
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [23:0]                  m_tdata,    // out_byte[7:0], written_count[18:8]
	output logic                         m_tlast,    // run_last
	output logic [1:0]                   m_tuser     // finished[0], failed[1]
);
	import fbpe_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	bundle_t bundle;
	logic    ser_free;
	logic    advance;
	logic    load;

	assign cfg_ready = 1'b1;

	// An item without results only updates the string state.
	assign advance = valid_s1 && (bundle.count == CountNone || ser_free);
	assign load = advance && bundle.count != CountNone;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= '{in_byte: s_tdata, first_byte: s_tuser[0], last_byte: s_tlast};
		end
	end

	fbpe_step #(
		.MAX_LEN(MAX_LEN)
	) u_step (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_data(cfg_data),
		.item(item_s1),
		.advance(advance),
		.bundle(bundle)
	);

	fbpe_serial u_serial (
		.clk(clk),
		.arst_n(arst_n),
		.load(load),
		.bundle_in(bundle),
		.free(ser_free),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

endmodule

`default_nettype wire
